// ===== rtl/hcbd_pkg.sv =====
// shared types and constants for the chunked body decoder
package hcbd_pkg;

  localparam int SIZE_DIGITS_DEF = 5;
  localparam int TOTAL_BITS_DEF  = 24;

  localparam int MAX_LEN_W = 24;
  localparam int TOT_LEN_W = 24;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = '1;

  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_LINE_LONG = 2'd1;
  localparam logic [1:0] ST_OUT_LONG  = 2'd2;
  localparam logic [1:0] ST_EARLY_END = 2'd3;

  typedef struct packed {
    logic                 has_byte;
    logic [7:0]           out_byte;
    logic                 finished;
    logic [1:0]           status;
    logic [TOT_LEN_W-1:0] total_length;
  } res_t;

endpackage

// ===== rtl/hcbd_core.sv =====
// message state and per-byte decode logic
module hcbd_core import hcbd_pkg::*; #(
  parameter int SIZE_DIGITS = SIZE_DIGITS_DEF,
  parameter int TOTAL_BITS  = TOTAL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [MAX_LEN_W-1:0] max_len,
  output logic                 res_valid,
  output res_t                 res
);

  localparam int LL_W  = $clog2(SIZE_DIGITS + 2);
  localparam int CS_W  = 4 * SIZE_DIGITS;
  localparam int DT_W  = TOTAL_BITS + 1;
  localparam int CMP_W = (DT_W > MAX_LEN_W) ? DT_W : MAX_LEN_W;
  localparam logic [LL_W-1:0] LL_MAX = LL_W'(SIZE_DIGITS);

  localparam logic [1:0] PH_SIZE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [7:0] CHR_CR = 8'h0d;
  localparam logic [7:0] CHR_LF = 8'h0a;

  typedef struct packed {
    logic [LL_W-1:0] ll;
    logic            hs;
    logic [CS_W-1:0] cs;
  } line_t;

  logic [1:0]      phase_r, phase_nxt;
  logic [LL_W-1:0] line_length_r, line_length_nxt;
  logic            pending_cr_r, pending_cr_nxt;
  logic            hex_stopped_r, hex_stopped_nxt;
  logic [CS_W-1:0] chunk_size_r, chunk_size_nxt;
  logic [CS_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]      skip_count_r, skip_count_nxt;
  logic [DT_W-1:0] decoded_total_r, decoded_total_nxt;

  logic            hit;
  logic            clr;
  res_t            r;
  line_t           ln;
  logic [TOTAL_BITS-1:0] sat_total;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b1, 4'(c - 8'h57)};
    return v;
  endfunction

  function automatic line_t add_char(input line_t s, input logic [7:0] c);
    line_t      o;
    logic [4:0] h;
    o = s;
    h = hex_digit(c);
    if (s.ll <= LL_MAX) o.ll = s.ll + 1'b1;
    if (!s.hs) begin
      if (!h[4] || o.ll > LL_MAX) o.hs = 1'b1;
      else o.cs = CS_W'({s.cs, h[3:0]});
    end
    return o;
  endfunction

  assign sat_total = decoded_total_r[TOTAL_BITS] ? '1 : decoded_total_r[TOTAL_BITS-1:0];

  always_comb begin
    phase_nxt         = phase_r;
    line_length_nxt   = line_length_r;
    pending_cr_nxt    = pending_cr_r;
    hex_stopped_nxt   = hex_stopped_r;
    chunk_size_nxt    = chunk_size_r;
    bytes_left_nxt    = bytes_left_r;
    skip_count_nxt    = skip_count_r;
    decoded_total_nxt = decoded_total_r;
    hit = 1'b0;
    clr = 1'b0;
    r   = '0;
    ln  = '{ll: line_length_r, hs: hex_stopped_r, cs: chunk_size_r};
    case (phase_r)
      PH_SIZE: begin
        if (pending_cr_r && data_byte == CHR_LF) begin
          pending_cr_nxt = 1'b0;
          if (line_length_r > LL_MAX) begin
            hit = 1'b1;
            r.finished = 1'b1;
            r.status = ST_LINE_LONG;
          end else if (chunk_size_r == '0) begin
            hit = 1'b1;
            r.finished = 1'b1;
            r.status = ST_OK;
            r.total_length = TOT_LEN_W'(sat_total);
          end else if (last_byte) begin
            hit = 1'b1;
            r.finished = 1'b1;
            r.status = ST_EARLY_END;
          end else begin
            phase_nxt       = PH_DATA;
            bytes_left_nxt  = chunk_size_r;
            chunk_size_nxt  = '0;
            line_length_nxt = '0;
            hex_stopped_nxt = 1'b0;
          end
        end else begin
          if (pending_cr_r) ln = add_char(ln, CHR_CR);
          if (data_byte != CHR_CR) ln = add_char(ln, data_byte);
          pending_cr_nxt  = (data_byte == CHR_CR);
          line_length_nxt = ln.ll;
          hex_stopped_nxt = ln.hs;
          chunk_size_nxt  = ln.cs;
          if (last_byte) begin
            hit = 1'b1;
            r.finished = 1'b1;
            r.status = ST_EARLY_END;
          end
        end
      end
      PH_DATA: begin
        if (!decoded_total_r[TOTAL_BITS]) decoded_total_nxt = decoded_total_r + 1'b1;
        if (bytes_left_r != '0) bytes_left_nxt = bytes_left_r - 1'b1;
        hit = 1'b1;
        r.has_byte = 1'b1;
        r.out_byte = data_byte;
        if (bytes_left_nxt == '0) begin
          if (CMP_W'(decoded_total_nxt) > CMP_W'(max_len)) begin
            r.finished = 1'b1;
            r.status = ST_OUT_LONG;
          end else if (last_byte) begin
            r.finished = 1'b1;
            r.status = ST_EARLY_END;
          end else begin
            phase_nxt = PH_SKIP;
            skip_count_nxt = 2'd2;
          end
        end else if (last_byte) begin
          r.finished = 1'b1;
          r.status = ST_EARLY_END;
        end
      end
      PH_SKIP: begin
        if (skip_count_r != 2'd0) skip_count_nxt = skip_count_r - 1'b1;
        if (skip_count_nxt == 2'd0) phase_nxt = PH_SIZE;
        if (last_byte) begin
          hit = 1'b1;
          r.finished = 1'b1;
          r.status = ST_EARLY_END;
        end
      end
      default: begin
        if (last_byte) clr = 1'b1;
      end
    endcase
    if (r.finished) begin
      phase_nxt = PH_DONE;
      if (last_byte) clr = 1'b1;
    end
    if (clr) begin
      phase_nxt         = PH_SIZE;
      line_length_nxt   = '0;
      pending_cr_nxt    = 1'b0;
      hex_stopped_nxt   = 1'b0;
      chunk_size_nxt    = '0;
      bytes_left_nxt    = '0;
      skip_count_nxt    = 2'd0;
      decoded_total_nxt = '0;
    end
  end

  assign res_valid = fire && hit;
  assign res       = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_SIZE;
      line_length_r   <= '0;
      pending_cr_r    <= 1'b0;
      hex_stopped_r   <= 1'b0;
      chunk_size_r    <= '0;
      bytes_left_r    <= '0;
      skip_count_r    <= 2'd0;
      decoded_total_r <= '0;
    end else if (fire) begin
      phase_r         <= phase_nxt;
      line_length_r   <= line_length_nxt;
      pending_cr_r    <= pending_cr_nxt;
      hex_stopped_r   <= hex_stopped_nxt;
      chunk_size_r    <= chunk_size_nxt;
      bytes_left_r    <= bytes_left_nxt;
      skip_count_r    <= skip_count_nxt;
      decoded_total_r <= decoded_total_nxt;
    end
  end

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.has_byte |-> res.out_byte == 8'd0)
    else $error("out_byte set without a data byte");

  a_open_clean: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.finished |-> res.status == ST_OK && res.total_length == '0)
    else $error("status or total set on an unfinished result");

  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.finished && !last_byte |=> phase_r == PH_DONE)
    else $error("no done phase after a finished result");

  a_left_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SIZE || phase_r == PH_SKIP |-> bytes_left_r == '0)
    else $error("data count left over outside the data phase");

endmodule

// ===== rtl/hcbd_out_buf.sv =====
// two-entry result buffer with a registered ready
module hcbd_out_buf import hcbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  res_t       ent_r [2];
  logic       head_r, head_nxt;
  logic       tail_r, tail_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign ready     = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = ent_r[head_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    head_nxt  = head_r ^ pop;
    tail_nxt  = tail_r ^ push;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      tail_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[tail_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != 2'd2)
    else $error("result pushed into a full buffer");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 2'd1)
    else $error("buffer count lost a request");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd0 || count_r == 2'd2 |-> head_r == tail_r)
    else $error("buffer pointers out of step");

endmodule

// ===== rtl/http_chunked_body_decoder.sv =====
// top level of the chunked transfer body decoder
// a result passes from the input register through hcbd_core into the result buffer before it can be taken
// throughput: one byte per cycle while the result buffer has room, set by the state update in hcbd_core
// a two-entry result buffer lets input flow while one result waits at the output
// reset: synchronous active-low rst_n clears the message state and buffers,
// and sets max output length to all ones
module http_chunked_body_decoder import hcbd_pkg::*; #(
  parameter int SIZE_DIGITS = SIZE_DIGITS_DEF,
  parameter int TOTAL_BITS  = TOTAL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // data_byte
  input  logic                   in_tlast,   // last_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_byte, status, total_length, zero pad
  output logic [OUT_TUSER_W-1:0] out_tuser,  // has_byte, finished
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MAX_LEN_W-1:0]   cfg_data
);

  logic                 in_valid_r, in_valid_nxt;
  logic [7:0]           in_byte_r;
  logic                 in_last_r;
  logic [MAX_LEN_W-1:0] max_len_r;
  logic                 buf_ready;
  logic                 fire;
  logic                 in_acc;
  logic                 res_valid;
  res_t                 res;
  res_t                 out_res;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid_r && buf_ready;
  assign in_tready = !in_valid_r || buf_ready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc) in_valid_nxt = 1'b1;
    else if (fire) in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      max_len_r  <= MAX_LEN_RST;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (cfg_valid && cfg_ready) max_len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  hcbd_core #(
    .SIZE_DIGITS (SIZE_DIGITS),
    .TOTAL_BITS  (TOTAL_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  hcbd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .ready     (buf_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = OUT_TDATA_W'({out_res.total_length, out_res.status, out_res.out_byte});
  assign out_tuser = {out_res.finished, out_res.has_byte};

  a_push_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_valid_r && buf_ready)
    else $error("result produced without a pending request");

  a_hold_unfired: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !buf_ready |=> in_valid_r && $stable(in_byte_r))
    else $error("pending request lost while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_tready)
    else $error("input stalled with an empty input register");

endmodule
